/* hw/rtl/bpt_pkg.sv */
// Shared types and constants for the binomial coefficient (Pascal row) core.
// No dependencies; imported by binomial_pascal_table_core and its testbench.
package bpt_pkg;

  localparam int IDX_W  = 6;   // width of n and p
  localparam int COEF_W = 64;  // width of one row entry and of the result

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t COEF_ONES = '1;
  localparam coef_t COEF_ONE  = coef_t'(1);

endpackage

/* hw/rtl/binomial_pascal_table_core.sv */
// Binomial coefficient core: C(n,p) built from Pascal's rule in an on-chip row store.
// Depends on bpt_pkg (types and constants).

// Each request (n, p) gives one result. Requests with p above n, p zero or p equal
// to n go from idle straight to the finish state. Otherwise the row store entries
// 0..k, k = min(p, n-p), are cleared, then rows 1..n are built in place, columns
// min(i,k) down to 1 of row i by read-add-write through the single-port-read row
// memory, and entry k is read back as the result. One request is worked on at a
// time; a finished result waits in the output register while the next request is
// taken. Additions saturate at all ones and set out_saturated; if k+1 exceeds MAX_N
// the result is all ones with out_saturated set.
module binomial_pascal_table_core #(
  parameter int MAX_N = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpt_pkg::idx_t      in_n_value,
  input  bpt_pkg::idx_t      in_p_value,
  output logic               out_valid,
  input  logic               out_ready,
  output bpt_pkg::coef_t     out_coefficient,
  output logic               out_saturated
);
  import bpt_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_ROWS  = 3'd2;
  localparam logic [2:0] S_PRIME = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_RDK   = 3'd5;
  localparam logic [2:0] S_WAITK = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  idx_t       n_r, n_nxt, k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  coef_t      hold_r, hold_nxt, res_r, res_nxt;
  logic       sat_r, sat_nxt;
  logic       out_valid_r, out_valid_nxt;
  coef_t      out_coef_r;
  logic       out_sat_r;
  logic       out_load;

  // Row store: one write and one registered read per cycle
  coef_t          row_mem [MAX_N];
  coef_t          rdata_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  coef_t          mem_wdata;

  // Request decode and step arithmetic
  idx_t                diff_np, k_req, top;
  logic [COEF_W:0]     sum;
  logic                carry;

  assign diff_np = in_n_value - in_p_value;
  assign k_req   = (in_p_value > diff_np) ? diff_np : in_p_value;
  assign top     = (i_r < k_r) ? i_r : k_r;
  assign sum     = {1'b0, hold_r} + {1'b0, rdata_r};
  assign carry   = sum[COEF_W];

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    sat_nxt   = sat_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(j_r);
    mem_raddr = AW'(j_r);
    mem_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt   = in_n_value;
          k_nxt   = k_req;
          j_nxt   = '0;
          sat_nxt = 1'b0;
          if (in_p_value > in_n_value) begin
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else if (in_p_value == '0 || in_p_value == in_n_value) begin
            res_nxt   = COEF_ONE;
            state_nxt = S_FIN;
          end else if (32'(k_req) + 32'd1 > 32'(MAX_N)) begin
            res_nxt   = COEF_ONES;
            sat_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CLR;
          end
        end
      end
      // entry 0 gets one, entries 1..k get zero
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = (j_r == '0) ? COEF_ONE : '0;
        if (j_r == k_r) begin
          i_nxt     = idx_t'(1);
          state_nxt = S_ROWS;
        end else begin
          j_nxt = j_r + idx_t'(1);
        end
      end
      // open a row: fetch the highest column touched
      S_ROWS: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(top);
        j_nxt     = top;
        state_nxt = S_PRIME;
      end
      S_PRIME: begin
        hold_nxt  = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = AW'(j_r - idx_t'(1));
        state_nxt = S_STEP;
      end
      // row[j] = row[j] + row[j-1], walking j downward; row[j-2] fetched ahead
      S_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = carry ? COEF_ONES : sum[COEF_W-1:0];
        sat_nxt   = sat_r | carry;
        hold_nxt  = rdata_r;
        if (j_r > idx_t'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(j_r - idx_t'(2));
          j_nxt     = j_r - idx_t'(1);
        end else if (i_r == n_r) begin
          state_nxt = S_RDK;
        end else begin
          i_nxt     = i_r + idx_t'(1);
          state_nxt = S_ROWS;
        end
      end
      S_RDK: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(k_r);
        state_nxt = S_WAITK;
      end
      S_WAITK: begin
        res_nxt   = sat_r ? COEF_ONES : rdata_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    if (out_load) begin
      out_coef_r <= res_r;
      out_sat_r  <= sat_r;
    end
  end

  // Row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= row_mem[mem_raddr];
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_saturated   = out_sat_r;

  // Checks
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_saturated || out_coefficient == COEF_ONES))
    else $error("saturated result is not all ones");

  a_step_col: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> (j_r >= idx_t'(1) && j_r <= k_r))
    else $error("column out of range during row update");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROWS |-> (i_r >= idx_t'(1) && i_r <= n_r))
    else $error("row index out of range");

  a_trivial_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_p_value > in_n_value) |=> state_r == S_FIN)
    else $error("p above n did not finish at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> !$past(out_load))
    else $error("pending result overwritten");

endmodule

/* tb/tb_binomial_pascal_table_core.sv */
// Self-checking testbench for binomial_pascal_table_core: drives (n, p) requests with
// random idle gaps and output stalls, and checks every C(n,p) against a Pascal-rule predictor.
// Depends on bpt_pkg and the binomial_pascal_table_core RTL.
module tb_binomial_pascal_table_core;
  import bpt_pkg::*;

  localparam int  ROW_DEPTH    = 64;          // matches MAX_N of the instance
  localparam int  LONG_HOLD    = 500;         // length of the receiver's one long hold-off
  localparam int  RANDOM_COUNT = 275;
  localparam longint RUN_LIMIT = 64'd30_000_000;

  typedef struct {
    coef_t coefficient;
    logic  saturated;
  } binom_result_t;

  // Predicts C(n,p) per request and checks results in order.
  class pascal_scoreboard;
    binom_result_t expected_q[$];
    int errors;
    int checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Pascal row built in place, saturating adds with a sticky overflow flag
    function binom_result_t binomial_expect(idx_t n, idx_t p);
      binom_result_t res;
      coef_t         row [ROW_DEPTH];
      logic [COEF_W:0] sum;
      int            k;
      int            top;
      logic          ovf;
      ovf = 1'b0;
      res.saturated = 1'b0;
      if (p > n) begin
        res.coefficient = '0;
        return res;
      end
      if (p == 0 || p == n) begin
        res.coefficient = COEF_ONE;
        return res;
      end
      k = (p > n - p) ? int'(n - p) : int'(p);
      if (k + 1 > ROW_DEPTH) begin
        res.coefficient = COEF_ONES;
        res.saturated   = 1'b1;
        return res;
      end
      foreach (row[j]) row[j] = '0;
      row[0] = COEF_ONE;
      for (int i = 1; i <= int'(n); i++) begin
        top = (i < k) ? i : k;
        for (int j = top; j >= 1; j--) begin
          sum = {1'b0, row[j]} + {1'b0, row[j-1]};
          if (sum[COEF_W]) begin
            ovf    = 1'b1;
            row[j] = COEF_ONES;
          end else begin
            row[j] = sum[COEF_W-1:0];
          end
        end
      end
      res.coefficient = ovf ? COEF_ONES : row[k];
      res.saturated   = ovf;
      return res;
    endfunction

    function void note_request(idx_t n, idx_t p);
      expected_q.push_back(binomial_expect(n, p));
    endfunction

    function void check_result(coef_t coef, logic sat);
      binom_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result coefficient=%0d saturated=%0b", $time, coef, sat);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (coef !== exp_r.coefficient) begin
        $display("%0t: coefficient mismatch: expected %0d, actual %0d",
                 $time, exp_r.coefficient, coef);
        errors++;
      end
      if (sat !== exp_r.saturated) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, exp_r.saturated, sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  idx_t  in_n_value;
  idx_t  in_p_value;
  logic  out_valid;
  logic  out_ready;
  coef_t out_coefficient;
  logic  out_saturated;

  pascal_scoreboard board;
  bit               burst_mode;

  binomial_pascal_table_core #(.MAX_N(ROW_DEPTH)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_n_value      (in_n_value),
    .in_p_value      (in_p_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coefficient (out_coefficient),
    .out_saturated   (out_saturated)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request from a falling edge, wait for acceptance, then idle for a random gap, if any
  task automatic send_request(input idx_t n, input idx_t p);
    int gap;
    in_n_value = n;
    in_p_value = p;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_request(n, p);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   = 1'b0;
      in_n_value = idx_t'($urandom);
      in_p_value = idx_t'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random request: mostly small rows, some up to full size, plus edge cases
  task automatic send_random_request();
    int   r;
    idx_t n;
    idx_t p;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      n = idx_t'($urandom);
      p = idx_t'($urandom);
    end else if (r < 25) begin
      n = idx_t'($urandom);
      p = ($urandom_range(0, 1) == 0) ? idx_t'(0) : n;
    end else if (r < 88) begin
      n = idx_t'($urandom_range(2, 24));
      p = idx_t'($urandom_range(1, n - 1));
    end else begin
      n = idx_t'($urandom_range(2, 63));
      p = idx_t'($urandom_range(1, n - 1));
    end
    send_request(n, p);
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_coefficient, out_saturated);
  end

  // Receiver: random ready/stall runs, plus one long hold-off
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int stall;
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = pick_gap();
      if (!long_hold_done && board.checked >= 30) begin
        stall          = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    board      = new();
    burst_mode = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_n_value = '0;
    in_p_value = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: zero and one indices, p above n, p equal n, widest rows
    send_request(6'd0,  6'd0);
    send_request(6'd0,  6'd63);
    send_request(6'd5,  6'd6);
    send_request(6'd1,  6'd0);
    send_request(6'd1,  6'd1);
    send_request(6'd2,  6'd1);
    send_request(6'd63, 6'd0);
    send_request(6'd63, 6'd63);
    send_request(6'd62, 6'd63);
    send_request(6'd63, 6'd1);
    send_request(6'd63, 6'd62);
    send_request(6'd10, 6'd5);
    send_request(6'd63, 6'd31);
    send_request(6'd63, 6'd32);
    send_request(6'd62, 6'd31);
    send_request(6'd42, 6'd21);
    send_request(6'd3,  6'd2);

    // Random: in chunks, some chunks with no idling on the input side and no random output stalls
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 25 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    burst_mode = 1'b0;
    in_valid   = 1'b0;

    // drain: poll once per cycle until every request has its result
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
